// ----- src/fsz_pkg.sv -----
// ----------------------------------------------------------------------------
// fsz_pkg
// Shared constants, types and helper functions for the frame shift block.
// ----------------------------------------------------------------------------
package fsz_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_SHIFT   = 8;
    localparam int STORE_DEPTH = 32768;

    // fixed field widths of the configuration registers and the pixel
    localparam int CFG_SIZE_W  = 11;
    localparam int CFG_SHIFT_W = 5;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 4 * CH_W;

    // derived widths
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int SHIFT_W = $clog2(MAX_SHIFT + 1) + 1;
    localparam int DELAY_W = $clog2(MAX_SHIFT * (MAX_WIDTH + 1) + 1);
    localparam int BACK_W  = $clog2(2 * MAX_SHIFT * (MAX_WIDTH + 1) + 1);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int PROD_W  = SHIFT_W + WID_W + 1;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_X_SHIFT      = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_Y_SHIFT      = CFG_INDEX_W'(3);

    // reset configuration
    localparam int RST_WIDTH  = 720;
    localparam int RST_HEIGHT = 480;
    localparam int RST_DELAY  = MAX_SHIFT * (RST_WIDTH + 1);
    localparam int RST_BACK   = RST_DELAY;

    typedef struct packed {
        logic [WID_W-1:0]          width;
        logic [HGT_W-1:0]          height;
        logic signed [SHIFT_W-1:0] x_shift;
        logic signed [SHIFT_W-1:0] y_shift;
        logic [DELAY_W-1:0]        delay;
        logic [BACK_W-1:0]         back;
    } cfg_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } res_t;

    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_SIZE_W-1:0] raw);
        int v;
        v = int'(raw);
        if (v < 1)
            v = 1;
        else if (v > MAX_WIDTH)
            v = MAX_WIDTH;
        return WID_W'(v);
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_SIZE_W-1:0] raw);
        int v;
        v = int'(raw);
        if (v < 1)
            v = 1;
        else if (v > MAX_HEIGHT)
            v = MAX_HEIGHT;
        return HGT_W'(v);
    endfunction

    function automatic logic signed [SHIFT_W-1:0] clamp_shift(
        input logic [CFG_SHIFT_W-1:0] raw
    );
        int v;
        v = int'($signed(raw));
        if (v > MAX_SHIFT)
            v = MAX_SHIFT;
        else if (v < -MAX_SHIFT)
            v = -MAX_SHIFT;
        return SHIFT_W'(v);
    endfunction

endpackage

// ----- src/fsz_cfg.sv -----
// ----------------------------------------------------------------------------
// fsz_cfg
// Configuration registers with clamping and precomputed delay and read offset.
// ----------------------------------------------------------------------------
module fsz_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fsz_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fsz_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fsz_pkg::cfg_t                    cfg,
    output logic                             restart
);

    fsz_pkg::cfg_t cfg_reg;
    fsz_pkg::cfg_t cfg_next;

    logic [fsz_pkg::WID_W-1:0]          w_sel;
    logic [fsz_pkg::HGT_W-1:0]          h_sel;
    logic signed [fsz_pkg::SHIFT_W-1:0] xs_sel;
    logic signed [fsz_pkg::SHIFT_W-1:0] ys_sel;
    logic [fsz_pkg::SHIFT_W:0]          row_mult;
    logic [fsz_pkg::PROD_W-1:0]         prod;
    logic [fsz_pkg::BACK_W-1:0]         xs_ext;

    always_comb
    begin
        w_sel   = cfg_reg.width;
        h_sel   = cfg_reg.height;
        xs_sel  = cfg_reg.x_shift;
        ys_sel  = cfg_reg.y_shift;
        restart = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                fsz_pkg::REG_FRAME_WIDTH:
                begin
                    w_sel   = fsz_pkg::clamp_width(cfg_data[fsz_pkg::CFG_SIZE_W-1:0]);
                    restart = 1'b1;
                end
                fsz_pkg::REG_FRAME_HEIGHT:
                begin
                    h_sel   = fsz_pkg::clamp_height(cfg_data[fsz_pkg::CFG_SIZE_W-1:0]);
                    restart = 1'b1;
                end
                fsz_pkg::REG_X_SHIFT:
                begin
                    xs_sel  = fsz_pkg::clamp_shift(cfg_data[fsz_pkg::CFG_SHIFT_W-1:0]);
                    restart = 1'b1;
                end
                fsz_pkg::REG_Y_SHIFT:
                begin
                    ys_sel  = fsz_pkg::clamp_shift(cfg_data[fsz_pkg::CFG_SHIFT_W-1:0]);
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        // read offset = (MAX_SHIFT + ys) * w + MAX_SHIFT + xs, never negative
        row_mult = (fsz_pkg::SHIFT_W+1)'(fsz_pkg::MAX_SHIFT)
                 + {ys_sel[fsz_pkg::SHIFT_W-1], ys_sel};
        prod     = fsz_pkg::PROD_W'(row_mult) * fsz_pkg::PROD_W'(w_sel);
        xs_ext   = fsz_pkg::BACK_W'(xs_sel);

        cfg_next.width   = w_sel;
        cfg_next.height  = h_sel;
        cfg_next.x_shift = xs_sel;
        cfg_next.y_shift = ys_sel;
        cfg_next.delay   = fsz_pkg::DELAY_W'(fsz_pkg::MAX_SHIFT * (int'(w_sel) + 1));
        cfg_next.back    = fsz_pkg::BACK_W'(prod) + fsz_pkg::BACK_W'(fsz_pkg::MAX_SHIFT)
                         + xs_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width   <= fsz_pkg::WID_W'(fsz_pkg::RST_WIDTH);
            cfg_reg.height  <= fsz_pkg::HGT_W'(fsz_pkg::RST_HEIGHT);
            cfg_reg.x_shift <= '0;
            cfg_reg.y_shift <= '0;
            cfg_reg.delay   <= fsz_pkg::DELAY_W'(fsz_pkg::RST_DELAY);
            cfg_reg.back    <= fsz_pkg::BACK_W'(fsz_pkg::RST_BACK);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/fsz_ring.sv -----
// ----------------------------------------------------------------------------
// fsz_ring
// Pixel ring memory with write/read address generation and output position.
// ----------------------------------------------------------------------------
module fsz_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fsz_pkg::cfg_t               cfg,
    input  logic                        restart,
    input  logic                        in_valid,
    input  logic [fsz_pkg::PIX_W-1:0]   in_pix,
    input  logic                        in_padding,
    output logic                        out_valid,
    output fsz_pkg::res_t               out_res
);

    logic [fsz_pkg::PIX_W-1:0] ring_mem [fsz_pkg::STORE_DEPTH];

    logic [fsz_pkg::ADDR_W-1:0]  wr_idx_reg;
    logic [fsz_pkg::DELAY_W-1:0] fill_reg;
    logic [fsz_pkg::ROW_W-1:0]   row_reg;
    logic [fsz_pkg::COL_W-1:0]   col_reg;

    logic                        s1_valid_reg;
    logic                        s1_in_frame_reg;
    logic                        s1_fwd_reg;
    logic                        s1_last_reg;
    logic [fsz_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [fsz_pkg::PIX_W-1:0]   rd_data_reg;

    logic [fsz_pkg::PIX_W-1:0]   pix;
    logic                        filling;
    logic                        produce;
    logic signed [fsz_pkg::COL_W+1:0] src_col;
    logic signed [fsz_pkg::ROW_W+1:0] src_row;
    logic                        in_frame;
    logic                        col_end;
    logic                        row_end;
    logic                        fwd;
    logic                        rd_en;
    logic [fsz_pkg::ADDR_W-1:0]  rd_addr;

    always_comb
    begin
        pix     = in_padding ? '0 : in_pix;
        filling = fill_reg < cfg.delay;
        produce = in_valid && !filling;

        src_col  = $signed({2'b00, col_reg}) - (fsz_pkg::COL_W+2)'(cfg.x_shift);
        src_row  = $signed({2'b00, row_reg}) - (fsz_pkg::ROW_W+2)'(cfg.y_shift);
        in_frame = (src_col >= 0) && (src_col < $signed({1'b0, cfg.width}))
                && (src_row >= 0) && (src_row < $signed({1'b0, cfg.height}));

        col_end = ((fsz_pkg::COL_W+1)'(col_reg) + (fsz_pkg::COL_W+1)'(1)) >= cfg.width;
        row_end = ((fsz_pkg::ROW_W+1)'(row_reg) + (fsz_pkg::ROW_W+1)'(1)) >= cfg.height;

        // zero offset reads the slot being written in this same cycle
        fwd     = (cfg.back == '0);
        rd_addr = wr_idx_reg - fsz_pkg::ADDR_W'(cfg.back);
        rd_en   = produce && in_frame && !fwd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            fill_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= produce;
            if (restart)
            begin
                wr_idx_reg <= '0;
                fill_reg   <= '0;
                row_reg    <= '0;
                col_reg    <= '0;
            end
            else if (in_valid)
            begin
                wr_idx_reg <= wr_idx_reg + fsz_pkg::ADDR_W'(1);
                if (filling)
                begin
                    fill_reg <= fill_reg + fsz_pkg::DELAY_W'(1);
                end
                else if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + fsz_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + fsz_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            s1_in_frame_reg <= in_frame;
            s1_fwd_reg      <= fwd;
            s1_last_reg     <= row_end && col_end;
            s1_pix_reg      <= pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            ring_mem[wr_idx_reg] <= pix;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign out_valid    = s1_valid_reg;
    assign out_res.last = s1_last_reg;
    assign out_res.pix  = !s1_in_frame_reg ? '0 : (s1_fwd_reg ? s1_pix_reg : rd_data_reg);

endmodule

// ----- src/fsz_fifo.sv -----
// ----------------------------------------------------------------------------
// fsz_fifo
// Small output queue that absorbs results while the receiver stalls.
// ----------------------------------------------------------------------------
module fsz_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  fsz_pkg::res_t                   push_data,
    input  logic                            pop,
    output logic                            out_valid,
    output fsz_pkg::res_t                   out_data,
    output logic [fsz_pkg::FIFO_CNT_W-1:0]  count
);

    fsz_pkg::res_t entry_mem [fsz_pkg::FIFO_DEPTH];

    logic [fsz_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [fsz_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [fsz_pkg::FIFO_CNT_W-1:0] cnt_reg;
    logic                           do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + fsz_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + fsz_pkg::FIFO_PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + fsz_pkg::FIFO_CNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - fsz_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_mem[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule

// ----- src/frame_shift_zero_fill.sv -----
// ----------------------------------------------------------------------------
// frame_shift_zero_fill
// Translates an RGBA raster stream by signed x/y shifts with zero fill.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one word per pixel,
// red in the low byte; s_axis_tuser marks a padding word whose pixel is
// stored as zero and is used to push the last frame out. Shifted pixels
// leave on m_axis, with m_axis_tlast on the last pixel of each output frame.
// Every input word is written into a 32768-entry ring memory. The first
// 8*(frame_width+1) words after reset or after any register write only fill
// the ring; from then on each input word yields one output word.
// An output word passes from the input through the ring read register and
// then through the output queue before it shows on m_axis.
// Throughput: one word per clock while m_axis does not stall, set by the
// single write port and single read port of the ring, both used once per word.
// Reset clears the stream position and fill count and loads 720x480 with
// zero shift; the ring itself is not cleared, since a slot is always
// written before it is read. The user must write registers only while the
// stream is idle; the block does not enforce this. When m_axis stalls, results
// collect in a four-word queue; s_axis_tready drops once queue and read stage hold four words.
// ----------------------------------------------------------------------------
module frame_shift_zero_fill (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fsz_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fsz_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fsz_pkg::PIX_W-1:0]        s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                             s_axis_tuser,  // padding
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fsz_pkg::PIX_W-1:0]        m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                             m_axis_tlast   // frame_end
);

    fsz_pkg::cfg_t                  cfg;
    logic                           restart;
    logic                           in_accept;
    logic                           ring_valid;
    fsz_pkg::res_t                  ring_res;
    fsz_pkg::res_t                  q_res;
    logic [fsz_pkg::FIFO_CNT_W-1:0] q_count;

    fsz_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    // room for the word in the read stage plus one more
    assign s_axis_tready = (q_count + fsz_pkg::FIFO_CNT_W'(ring_valid))
                         < fsz_pkg::FIFO_CNT_W'(fsz_pkg::FIFO_DEPTH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    fsz_ring u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .restart    (restart),
        .in_valid   (in_accept),
        .in_pix     (s_axis_tdata),
        .in_padding (s_axis_tuser),
        .out_valid  (ring_valid),
        .out_res    (ring_res)
    );

    fsz_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ring_valid),
        .push_data (ring_res),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (q_res),
        .count     (q_count)
    );

    assign m_axis_tdata = q_res.pix;
    assign m_axis_tlast = q_res.last;

endmodule

// ----- src/fsz_checker.sv -----
// ----------------------------------------------------------------------------
// fsz_checker
// Port-level checks for the frame shift block, bound to the top level.
// ----------------------------------------------------------------------------
module fsz_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [fsz_pkg::PIX_W-1:0] m_axis_tdata,
    input  logic                      m_axis_tlast
);

    logic [31:0] pending_reg;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // words taken minus words delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 32'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_reg <= pending_reg - 32'd1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 32'd0)
        else $error("output word without a matching input word");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while no output word waits");

endmodule

bind frame_shift_zero_fill fsz_checker u_fsz_checker (.*);
